### rtl/core/mws_pkg.sv
// Package for the matrix window store: item types, request codes and the
// sequencer state type. Depends on nothing; the top level imports it.
package mws_pkg;

    localparam int unsigned STORE_ROWS = 16;
    localparam int unsigned STORE_COLS = 16;
    localparam int unsigned DEPTH      = STORE_ROWS * STORE_COLS;
    localparam int unsigned ADDR_BITS  = $clog2(DEPTH);

    localparam logic [31:0] ONE_WORD = 32'h3F80_0000;

    localparam logic [2:0] REQ_RD_RC  = 3'd0;
    localparam logic [2:0] REQ_WR_RC  = 3'd1;
    localparam logic [2:0] REQ_RD_IDX = 3'd2;
    localparam logic [2:0] REQ_WR_IDX = 3'd3;
    localparam logic [2:0] REQ_ZEROS  = 3'd4;
    localparam logic [2:0] REQ_ONES   = 3'd5;
    localparam logic [2:0] REQ_IDENT  = 3'd6;
    localparam logic [2:0] REQ_XLOAD  = 3'd7;

    localparam logic [1:0] REG_ORIGIN_ROW = 2'd0;
    localparam logic [1:0] REG_ORIGIN_COL = 2'd1;
    localparam logic [1:0] REG_SHAPE_ROWS = 2'd2;
    localparam logic [1:0] REG_SHAPE_COLS = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        load_mode;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [7:0]  lin_index;
        logic [31:0] write_data;
        logic        load_first;
        logic        load_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        status;
        logic [4:0]  now_rows;
        logic [4:0]  now_cols;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_ACCESS,
        S_RDOUT,
        S_FILL,
        S_TRR1,
        S_TRW1,
        S_TRR2,
        S_TRW2
    } state_t;

endpackage

### rtl/core/matrix_window_store.sv
// Matrix window store: column-major word memory with a movable window.
// Depends on mws_pkg for item types, request codes and the state type.
//
// Steps: a rejected item, an element write by row and column and a load
// element are done at acceptance; a read by row and column adds a read-out
// step; a linear-index write takes an 8-step restoring division and an
// access step, and a linear-index read adds a read-out step after those.
// Fills write the window word by word; a transpose copies the window to a
// scratch memory and back, with a read step and a write step per word.
// One item is in work at a time; busy is high until its result is shown.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset clears the shape to 16 x 16, origin and load position to zero; the
// word memory holds nothing defined until written.
module matrix_window_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mws_pkg::in_item_t     item,
    output logic                  done,
    output mws_pkg::out_item_t    result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import mws_pkg::*;

    state_t        state_reg, state_next;
    logic [3:0]    orow_reg, orow_next;
    logic [3:0]    ocol_reg, ocol_next;
    logic [4:0]    rows_reg, rows_next;
    logic [4:0]    cols_reg, cols_next;
    logic [3:0]    lrow_reg, lrow_next;
    logic [4:0]    lcol_reg, lcol_next;
    in_item_t      req_reg, req_next;
    logic [3:0]    r_reg, r_next;
    logic [3:0]    c_reg, c_next;
    logic [7:0]    lin_reg, lin_next;
    logic [7:0]    divq_reg, divq_next;
    logic [3:0]    divr_reg, divr_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          done_reg, done_next;
    out_item_t     res_reg, res_next;

    logic [31:0]           store_mem [DEPTH];
    logic [31:0]           scratch_mem [DEPTH];
    logic [31:0]           store_q, scratch_q;
    logic                  st_we, sc_we;
    logic [ADDR_BITS-1:0]  st_waddr, st_raddr, sc_waddr, sc_raddr;
    logic [31:0]           st_wdata, sc_wdata;

    logic          accept, cfg_wr;
    logic          win_ok, acc_ok, fit_ok, idx_ok, rc_ok;
    logic [9:0]    area;
    logic [4:0]    ld_r, ld_c;
    logic          ld_ok;
    logic          r_last, c_last;
    logic [4:0]    rem_sh;
    logic          rem_ge;

    function automatic logic [ADDR_BITS-1:0] addr_of(input logic [3:0] orow,
                                                     input logic [3:0] ocol,
                                                     input logic [3:0] r,
                                                     input logic [3:0] c);
        logic [3:0] ra, ca;
        ra = orow + r;
        ca = ocol + c;
        return {ca, ra};
    endfunction

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign done   = done_reg;
    assign result = res_reg;

    // Range checks for the incoming item against the current window.
    assign win_ok = (rows_reg != 5'd0) && (cols_reg != 5'd0)
                 && ({2'b00, orow_reg} + {1'b0, rows_reg} <= 6'd16)
                 && ({2'b00, ocol_reg} + {1'b0, cols_reg} <= 6'd16);
    assign fit_ok = ({2'b00, orow_reg} + {1'b0, cols_reg} <= 6'd16)
                 && ({2'b00, ocol_reg} + {1'b0, rows_reg} <= 6'd16);
    assign area   = rows_reg * cols_reg;
    assign idx_ok = {2'b00, item.lin_index} < area;
    assign rc_ok  = ({1'b0, item.row} < rows_reg) && ({1'b0, item.col} < cols_reg);

    // Next position of a row-major load element.
    always_comb
    begin
        ld_r = item.load_first ? 5'd0 : {1'b0, lrow_reg};
        ld_c = item.load_first ? 5'd0 : lcol_reg;
        if (ld_c >= cols_reg)
        begin
            ld_r = ld_r + 5'd1;
            ld_c = 5'd0;
        end
        ld_ok = ld_r < rows_reg;
    end

    always_comb
    begin
        acc_ok = win_ok;
        case (item.req_type) inside
            REQ_RD_RC, REQ_WR_RC:   acc_ok = win_ok && rc_ok;
            REQ_RD_IDX, REQ_WR_IDX: acc_ok = win_ok && idx_ok;
            REQ_XLOAD:              acc_ok = win_ok && (item.load_mode ? ld_ok : fit_ok);
            default:                acc_ok = win_ok;
        endcase
    end

    assign r_last = ({1'b0, r_reg} == rows_reg - 5'd1);
    assign c_last = ({1'b0, c_reg} == cols_reg - 5'd1);
    assign rem_sh = {divr_reg, divq_reg[7]};
    assign rem_ge = rem_sh >= rows_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && acc_ok)
                begin
                    case (item.req_type) inside
                        REQ_RD_RC:                       state_next = S_RDOUT;
                        REQ_RD_IDX, REQ_WR_IDX:          state_next = S_DIV;
                        REQ_ZEROS, REQ_ONES, REQ_IDENT:  state_next = S_FILL;
                        REQ_XLOAD:  state_next = item.load_mode ? S_IDLE : S_TRR1;
                        default:                         state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:    state_next = (cnt_reg == 3'd7) ? S_ACCESS : S_DIV;
            S_ACCESS: state_next = (req_reg.req_type == REQ_RD_IDX) ? S_RDOUT : S_IDLE;
            S_RDOUT:  state_next = S_IDLE;
            S_FILL:   state_next = (r_last && c_last) ? S_IDLE : S_FILL;
            S_TRR1:   state_next = S_TRW1;
            S_TRW1:   state_next = (r_last && c_last) ? S_TRR2 : S_TRR1;
            S_TRR2:   state_next = S_TRW2;
            S_TRW2:   state_next = (r_last && c_last) ? S_IDLE : S_TRR2;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath, memory controls and result.
    always_comb
    begin
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        rows_next = rows_reg;
        cols_next = cols_reg;
        lrow_next = lrow_reg;
        lcol_next = lcol_reg;
        req_next  = req_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        lin_next  = lin_reg;
        divq_next = divq_reg;
        divr_next = divr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        st_we     = 1'b0;
        st_waddr  = addr_of(orow_reg, ocol_reg, r_reg, c_reg);
        st_wdata  = req_reg.write_data;
        st_raddr  = addr_of(orow_reg, ocol_reg, r_reg, c_reg);
        sc_we     = 1'b0;
        sc_waddr  = lin_reg;
        sc_wdata  = store_q;
        sc_raddr  = lin_reg;
        res_next.read_data = '0;
        res_next.status    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                r_next   = 4'd0;
                c_next   = 4'd0;
                lin_next = 8'd0;
                st_raddr = addr_of(orow_reg, ocol_reg, item.row, item.col);
                if (accept)
                begin
                    req_next  = item;
                    divq_next = item.lin_index;
                    divr_next = 4'd0;
                    cnt_next  = 3'd0;
                    if (!acc_ok)
                    begin
                        done_next       = 1'b1;
                        res_next.status = 1'b1;
                    end
                    else if (item.req_type == REQ_WR_RC)
                    begin
                        st_we     = 1'b1;
                        st_waddr  = addr_of(orow_reg, ocol_reg, item.row, item.col);
                        st_wdata  = item.write_data;
                        done_next = 1'b1;
                    end
                    else if (item.req_type == REQ_XLOAD && item.load_mode)
                    begin
                        st_we     = 1'b1;
                        st_waddr  = addr_of(orow_reg, ocol_reg, ld_r[3:0], ld_c[3:0]);
                        st_wdata  = item.write_data;
                        lrow_next = item.load_last ? 4'd0 : ld_r[3:0];
                        lcol_next = item.load_last ? 5'd0 : ld_c + 5'd1;
                        done_next = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                divr_next = rem_ge ? 4'(rem_sh - rows_reg) : rem_sh[3:0];
                divq_next = {divq_reg[6:0], rem_ge};
                cnt_next  = cnt_reg + 3'd1;
            end
            S_ACCESS:
            begin
                st_raddr = addr_of(orow_reg, ocol_reg, divr_reg, divq_reg[3:0]);
                st_waddr = st_raddr;
                if (req_reg.req_type == REQ_WR_IDX)
                begin
                    st_we     = 1'b1;
                    done_next = 1'b1;
                end
            end
            S_RDOUT:
            begin
                done_next          = 1'b1;
                res_next.read_data = store_q;
            end
            S_FILL:
            begin
                st_we = 1'b1;
                case (req_reg.req_type)
                    REQ_ONES:  st_wdata = ONE_WORD;
                    REQ_IDENT: st_wdata = (r_reg == c_reg) ? ONE_WORD : '0;
                    default:   st_wdata = '0;
                endcase
                r_next = r_last ? 4'd0 : r_reg + 4'd1;
                c_next = r_last ? c_reg + 4'd1 : c_reg;
                done_next = r_last && c_last;
            end
            S_TRR1:
            begin
                st_raddr = addr_of(orow_reg, ocol_reg, r_reg, c_reg);
            end
            S_TRW1:
            begin
                sc_we    = 1'b1;
                r_next   = r_last ? 4'd0 : r_reg + 4'd1;
                c_next   = r_last ? c_reg + 4'd1 : c_reg;
                lin_next = lin_reg + 8'd1;
                if (r_last && c_last)
                begin
                    c_next   = 4'd0;
                    lin_next = 8'd0;
                end
            end
            S_TRR2:
            begin
                sc_raddr = lin_reg;
            end
            S_TRW2:
            begin
                // Element (r, c) of the old window lands at (c, r) of the new one.
                st_we    = 1'b1;
                st_waddr = addr_of(orow_reg, ocol_reg, c_reg, r_reg);
                st_wdata = scratch_q;
                r_next   = r_last ? 4'd0 : r_reg + 4'd1;
                c_next   = r_last ? c_reg + 4'd1 : c_reg;
                lin_next = lin_reg + 8'd1;
                if (r_last && c_last)
                begin
                    rows_next = cols_reg;
                    cols_next = rows_reg;
                    done_next = 1'b1;
                end
            end
            default: ;
        endcase

        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ORIGIN_ROW: orow_next = pwdata[3:0];
                REG_ORIGIN_COL: ocol_next = pwdata[3:0];
                REG_SHAPE_ROWS: rows_next = pwdata[4:0];
                REG_SHAPE_COLS: cols_next = pwdata[4:0];
                default: ;
            endcase
        end

        res_next.now_rows = rows_next;
        res_next.now_cols = cols_next;
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ORIGIN_ROW: prdata = {28'd0, orow_reg};
            REG_ORIGIN_COL: prdata = {28'd0, ocol_reg};
            REG_SHAPE_ROWS: prdata = {27'd0, rows_reg};
            REG_SHAPE_COLS: prdata = {27'd0, cols_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            orow_reg  <= 4'd0;
            ocol_reg  <= 4'd0;
            rows_reg  <= 5'd16;
            cols_reg  <= 5'd16;
            lrow_reg  <= 4'd0;
            lcol_reg  <= 5'd0;
            r_reg     <= 4'd0;
            c_reg     <= 4'd0;
            lin_reg   <= 8'd0;
            cnt_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            orow_reg  <= orow_next;
            ocol_reg  <= ocol_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            lrow_reg  <= lrow_next;
            lcol_reg  <= lcol_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            lin_reg   <= lin_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        divq_reg <= divq_next;
        divr_reg <= divr_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        store_q <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
            scratch_mem[sc_waddr] <= sc_wdata;
        scratch_q <= scratch_mem[sc_raddr];
    end

    a_ok_shape: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.status |-> result.now_rows != 5'd0 && result.now_cols != 5'd0)
        else $error("successful item reported an empty window");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status |-> result.read_data == '0)
        else $error("rejected item carried read data");

    a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |=> state_reg == S_DIV || state_reg == S_ACCESS)
        else $error("division left early");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> state_reg == S_IDLE || state_reg == S_FILL
                  || state_reg == S_TRW2 || state_reg == S_ACCESS)
        else $error("store written outside a writing step");

endmodule

### verif/tb.sv
// Self-checking testbench for matrix_window_store: a directed table, then
// phases of random items under several window settings over the APB port.
// Depends on mws_pkg and the matrix_window_store RTL.
`timescale 1ns / 100ps

module tb;
    import mws_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned NUM_PHASES = 10;
    localparam int unsigned ITEMS_PER_PHASE = 70;

    // One row of the directed table: either a register write or an item,
    // with the expected result typed in where it is obvious.
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_sel;
        logic [31:0] reg_val;
        in_item_t    req;
        bit          typed;
        out_item_t   want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_item_t    item = '0;
    logic        done;
    out_item_t   result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the block: word memory, window and load position.
    logic [31:0] words [DEPTH];
    logic [3:0]  win_org_row, win_org_col;
    logic [4:0]  win_rows, win_cols;
    logic [3:0]  fill_row;
    logic [4:0]  fill_col;

    out_item_t   pending[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          rejects_seen = 0;
    int unsigned idle_cycles = 0;
    plan_row_t   plan[$];

    matrix_window_store DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned word_addr(int unsigned r, int unsigned c);
        int unsigned a;
        a = (win_org_col + c) * STORE_ROWS + win_org_row + r;
        return (a < DEPTH) ? a : 0;
    endfunction

    // Applies one item to the shadow state and returns the result it gives.
    function automatic out_item_t apply_request(in_item_t req);
        out_item_t   res;
        bit          ok;
        int unsigned r, c, tmp, area;
        logic [31:0] scratch [DEPTH];
        r = {28'd0, req.row};
        c = {28'd0, req.col};
        res = '0;
        area = win_rows * win_cols;
        ok = win_rows >= 1 && win_cols >= 1 &&
             win_org_row + win_rows <= STORE_ROWS &&
             win_org_col + win_cols <= STORE_COLS;
        if (ok)
        begin
            if (req.req_type == REQ_RD_IDX || req.req_type == REQ_WR_IDX)
            begin
                if (req.lin_index < area)
                begin
                    r = req.lin_index % win_rows;
                    c = req.lin_index / win_rows;
                end
                else
                    ok = 0;
            end
            else if (req.req_type == REQ_RD_RC || req.req_type == REQ_WR_RC)
                ok = r < win_rows && c < win_cols;
        end
        if (ok)
        begin
            case (req.req_type) inside
                REQ_RD_RC, REQ_RD_IDX: res.read_data = words[word_addr(r, c)];
                REQ_WR_RC, REQ_WR_IDX: words[word_addr(r, c)] = req.write_data;
                REQ_ZEROS, REQ_ONES, REQ_IDENT:
                begin
                    for (int cc = 0; cc < win_cols; cc++)
                        for (int rr = 0; rr < win_rows; rr++)
                            words[word_addr(rr, cc)] =
                                (req.req_type == REQ_ONES ||
                                 (req.req_type == REQ_IDENT && rr == cc)) ? ONE_WORD : '0;
                end
                default:
                begin
                    if (req.load_mode)
                    begin
                        r = req.load_first ? 0 : fill_row;
                        c = req.load_first ? 0 : fill_col;
                        if (c >= win_cols)
                        begin
                            r++;
                            c = 0;
                        end
                        if (r >= win_rows)
                            ok = 0;
                        else
                        begin
                            words[word_addr(r, c)] = req.write_data;
                            c++;
                            if (req.load_last)
                            begin
                                r = 0;
                                c = 0;
                            end
                            fill_row = r[3:0];
                            fill_col = c[4:0];
                        end
                    end
                    else if (win_org_row + win_cols > STORE_ROWS ||
                             win_org_col + win_rows > STORE_COLS)
                        ok = 0;
                    else
                    begin
                        for (int cc = 0; cc < win_cols; cc++)
                            for (int rr = 0; rr < win_rows; rr++)
                                scratch[cc * win_rows + rr] = words[word_addr(rr, cc)];
                        for (int cc = 0; cc < win_cols; cc++)
                            for (int rr = 0; rr < win_rows; rr++)
                                words[word_addr(cc, rr)] = scratch[cc * win_rows + rr];
                        tmp = win_rows;
                        win_rows = win_cols;
                        win_cols = tmp[4:0];
                    end
                end
            endcase
        end
        res.status = !ok;
        res.now_rows = win_rows;
        res.now_cols = win_cols;
        return res;
    endfunction

    function automatic in_item_t make_req(logic [2:0] kind, logic mode, logic [3:0] r,
                                          logic [3:0] c, logic [7:0] idx,
                                          logic [31:0] data, logic first, logic last);
        in_item_t req;
        req.req_type = kind;
        req.load_mode = mode;
        req.row = r;
        req.col = c;
        req.lin_index = idx;
        req.write_data = data;
        req.load_first = first;
        req.load_last = last;
        return req;
    endfunction

    function automatic out_item_t make_res(logic [31:0] rd, logic st, logic [4:0] nr,
                                           logic [4:0] nc);
        out_item_t res;
        res.read_data = rd;
        res.status = st;
        res.now_rows = nr;
        res.now_cols = nc;
        return res;
    endfunction

    task automatic add_item(in_item_t req, bit typed = 0, out_item_t want = '0);
        plan_row_t p;
        p.is_cfg = 0;
        p.reg_sel = REG_ORIGIN_ROW;
        p.reg_val = '0;
        p.req = req;
        p.typed = typed;
        p.want = want;
        plan.push_back(p);
    endtask

    task automatic add_cfg(logic [1:0] sel, logic [31:0] val);
        plan_row_t p;
        p = '{default: '0};
        p.is_cfg = 1;
        p.reg_sel = sel;
        p.reg_val = val;
        plan.push_back(p);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic reg_write(logic [1:0] sel, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (sel)
            REG_ORIGIN_ROW: win_org_row = val[3:0];
            REG_ORIGIN_COL: win_org_col = val[3:0];
            REG_SHAPE_ROWS: win_rows = val[4:0];
            default:        win_cols = val[4:0];
        endcase
    endtask

    // Every item gives exactly one result, so an empty queue means idle.
    task automatic wait_drained();
        while (pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Offers one item after a random gap and returns at the edge that takes it.
    // The shadow model is updated at that same edge.
    task automatic send_item(in_item_t req, bit typed = 0, out_item_t want = '0);
        int unsigned gap;
        out_item_t   predicted;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= req;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predicted = apply_request(req);
        pending.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic write_window(logic [3:0] orow, logic [3:0] ocol, logic [4:0] nr,
                                logic [4:0] nc);
        start <= 1'b0;
        wait_drained();
        reg_write(REG_ORIGIN_ROW, {28'd0, orow});
        reg_write(REG_ORIGIN_COL, {28'd0, ocol});
        reg_write(REG_SHAPE_ROWS, {27'd0, nr});
        reg_write(REG_SHAPE_COLS, {27'd0, nc});
    endtask

    // Random item biased toward the current window so most of them succeed.
    function automatic in_item_t random_req();
        in_item_t    req;
        logic [63:0] raw;
        int unsigned pick, area;
        raw = {$urandom, $urandom};
        req = raw[$bits(in_item_t)-1:0];
        area = win_rows * win_cols;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            req.req_type = REQ_RD_RC;
            if ($urandom_range(0, 7) != 0 && win_rows != 0 && win_cols != 0)
            begin
                req.row = 4'($urandom_range(0, win_rows - 1));
                req.col = 4'($urandom_range(0, win_cols - 1));
            end
        end
        else if (pick < 38)
        begin
            req.req_type = REQ_WR_RC;
            if ($urandom_range(0, 7) != 0 && win_rows != 0 && win_cols != 0)
            begin
                req.row = 4'($urandom_range(0, win_rows - 1));
                req.col = 4'($urandom_range(0, win_cols - 1));
            end
        end
        else if (pick < 70)
        begin
            req.req_type = (pick < 55) ? REQ_RD_IDX : REQ_WR_IDX;
            if ($urandom_range(0, 7) != 0 && area != 0)
                req.lin_index = 8'($urandom_range(0, (area > 256 ? 256 : area) - 1));
        end
        else if (pick < 76)
            req.req_type = REQ_ZEROS + 3'($urandom_range(0, 2));
        else if (pick < 81)
        begin
            req.req_type = REQ_XLOAD;
            req.load_mode = 1'b0;
        end
        else if (pick < 88)
        begin
            req.req_type = REQ_XLOAD;
            req.load_mode = 1'b1;
        end
        return req;
    endfunction

    // A row-major load run with random contents, sized to the window if it holds 1 to 40 words.
    task automatic send_load_run();
        int unsigned n;
        in_item_t    req;
        n = win_rows * win_cols;
        if (n == 0 || n > 40)
            n = $urandom_range(2, 20);
        for (int i = 0; i < n; i++)
        begin
            req = make_req(REQ_XLOAD, 1'b1, 4'($urandom), 4'($urandom), 8'($urandom),
                           $urandom, i == 0, i == n - 1);
            send_item(req);
        end
    endtask

    // Every result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %h", result);
                fail_count++;
            end
            else
            begin
                want = pending.pop_front();
                if (result.status)
                    rejects_seen++;
                if (result.read_data !== want.read_data)
                begin
                    $error("read_data expected %h actual %h", want.read_data,
                           result.read_data);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.now_rows !== want.now_rows)
                begin
                    $error("now_rows expected %0d actual %0d", want.now_rows,
                           result.now_rows);
                    fail_count++;
                end
                if (result.now_cols !== want.now_cols)
                begin
                    $error("now_cols expected %0d actual %0d", want.now_cols,
                           result.now_cols);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] orow, ocol;
        logic [4:0] nr, nc;
        win_org_row = '0;
        win_org_col = '0;
        win_rows = 5'd16;
        win_cols = 5'd16;
        fill_row = '0;
        fill_col = '0;

        // Directed table. The very first item zeroes the whole store, so no
        // later read can touch a word that was never written.
        add_item(make_req(REQ_ZEROS, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 0, 16, 16));
        add_item(make_req(REQ_RD_RC, 0, 15, 15, 0, 0, 0, 0), 1, make_res(0, 0, 16, 16));
        add_item(make_req(REQ_WR_RC, 0, 15, 15, 0, 32'hFFFF_FFFF, 0, 0), 1,
                 make_res(0, 0, 16, 16));
        add_item(make_req(REQ_RD_IDX, 0, 0, 0, 255, 0, 0, 0), 1,
                 make_res(32'hFFFF_FFFF, 0, 16, 16));
        add_item(make_req(REQ_WR_IDX, 0, 0, 0, 0, 32'h8000_0001, 0, 0));
        add_item(make_req(REQ_ONES, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 0, 16, 16));
        add_item(make_req(REQ_RD_RC, 0, 3, 9, 0, 0, 0, 0), 1,
                 make_res(ONE_WORD, 0, 16, 16));
        add_item(make_req(REQ_IDENT, 0, 0, 0, 0, 0, 0, 0));
        add_item(make_req(REQ_RD_RC, 0, 4, 4, 0, 0, 0, 0), 1,
                 make_res(ONE_WORD, 0, 16, 16));
        add_item(make_req(REQ_RD_RC, 0, 2, 3, 0, 0, 0, 0), 1, make_res(0, 0, 16, 16));
        add_item(make_req(REQ_XLOAD, 1, 0, 0, 0, 32'h1111_0000, 1, 0));
        add_item(make_req(REQ_XLOAD, 1, 0, 0, 0, 32'h2222_0000, 0, 0));
        add_item(make_req(REQ_XLOAD, 1, 0, 0, 0, 32'h3333_0000, 0, 1));
        add_item(make_req(REQ_XLOAD, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 0, 16, 16));
        add_item(make_req(REQ_RD_RC, 0, 2, 0, 0, 0, 0, 0));
        // Non-square window: out-of-range element and index, then a transpose
        // that swaps the shape.
        add_cfg(REG_SHAPE_ROWS, 4);
        add_cfg(REG_SHAPE_COLS, 3);
        add_item(make_req(REQ_RD_RC, 0, 4, 0, 0, 0, 0, 0), 1, make_res(0, 1, 4, 3));
        add_item(make_req(REQ_WR_IDX, 0, 0, 0, 12, 32'h5, 0, 0), 1, make_res(0, 1, 4, 3));
        add_item(make_req(REQ_XLOAD, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 0, 3, 4));
        add_item(make_req(REQ_RD_IDX, 0, 0, 0, 11, 0, 0, 0));
        // Window that no longer fits in the store, and a transpose that
        // would not fit after the swap.
        add_cfg(REG_ORIGIN_ROW, 15);
        add_item(make_req(REQ_ZEROS, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 1, 3, 4));
        add_cfg(REG_ORIGIN_ROW, 13);
        add_item(make_req(REQ_XLOAD, 0, 0, 0, 0, 0, 0, 0), 1, make_res(0, 1, 3, 4));
        add_cfg(REG_ORIGIN_ROW, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                start <= 1'b0;
                wait_drained();
                reg_write(plan[i].reg_sel, plan[i].reg_val);
            end
            else
                send_item(plan[i].req, plan[i].typed, plan[i].want);
        end

        // Random phases: the first ones use the extremes of the window.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: write_window(0, 0, 16, 16);
                1: write_window(15, 15, 1, 1);
                2: write_window(0, 15, 16, 1);
                3: write_window(15, 0, 1, 16);
                default:
                begin
                    orow = 4'($urandom);
                    ocol = 4'($urandom);
                    nr = 5'($urandom_range(1, 16 - orow));
                    nc = 5'($urandom_range(1, 16 - ocol));
                    if ($urandom_range(0, 5) == 0)
                        nr = 5'($urandom);
                    if ($urandom_range(0, 5) == 0)
                        nc = 5'($urandom);
                    write_window(orow, ocol, nr, nc);
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; )
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_load_run();
                    k += 8;
                end
                else
                begin
                    send_item(random_req());
                    k++;
                end
            end
        end

        start <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("tb: %0d items sent, %0d results checked, %0d of them range errors,",
                 items_sent, results_seen, rejects_seen);
        $display("tb: over %0d window settings with fills, transposes and row loads.",
                 NUM_PHASES + 3);
        if (fail_count == 0 && pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
